>>> design/nva_pkg.sv
// Shared types and codes for the note voice allocator.
// Holds the policy and mode codes, the classified event and the result beat.
// No dependencies.
package nva_pkg;

  // Policy register codes (the unused code decodes as round robin).
  localparam logic [1:0] POL_BCAST = 2'd0;
  localparam logic [1:0] POL_FIRST = 2'd1;
  localparam logic [1:0] POL_RR    = 2'd2;

  // Event mode codes.
  localparam logic MODE_ON  = 1'b0;
  localparam logic MODE_OFF = 1'b1;

  // Register indexes on the configuration port.
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

  localparam int NOTE_W  = 7;
  localparam int MASK_W  = 8;
  localparam int FIRST_W = 3;

  // Operation chosen by the front end for one event.
  typedef enum logic [2:0] {
    OP_ON_ALL,
    OP_ON_FIRST,
    OP_ON_RR,
    OP_OFF_ALL,
    OP_OFF_FIRST,
    OP_OFF_RR
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [NOTE_W-1:0] note;
  } evt_t;

  typedef struct packed {
    logic [MASK_W-1:0]  touched_mask;
    logic               found;
    logic [FIRST_W-1:0] first_device;
  } res_t;

endpackage

>>> design/nva_fifo.sv
// Two-entry first-in first-out queue of W-bit beats.
// Used between the front end, the allocation engine and the result port.
// No dependencies.
module nva_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_wr;
  logic         do_rd;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= ~wr_ptr;
      if (do_rd) rd_ptr <= ~rd_ptr;
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

endmodule

>>> design/nva_front.sv
// Front end: accepts note events and classifies each into an operation.
// Depends on nva_pkg and nva_fifo.
module nva_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    mode,
  input  logic [nva_pkg::NOTE_W-1:0] note,
  input  logic [1:0]              policy,
  output logic                    evt_valid,
  input  logic                    evt_take,
  output nva_pkg::evt_t           evt
);

  nva_pkg::evt_t cls;
  logic          q_empty;
  logic [$bits(nva_pkg::evt_t)-1:0] q_data;

  // Map mode and policy to one operation.
  always_comb begin
    cls.note = note;
    unique case (policy)
      nva_pkg::POL_BCAST: begin
        cls.op = (mode == nva_pkg::MODE_OFF) ? nva_pkg::OP_OFF_ALL : nva_pkg::OP_ON_ALL;
      end
      nva_pkg::POL_FIRST: begin
        cls.op = (mode == nva_pkg::MODE_OFF) ? nva_pkg::OP_OFF_FIRST : nva_pkg::OP_ON_FIRST;
      end
      default: begin
        cls.op = (mode == nva_pkg::MODE_OFF) ? nva_pkg::OP_OFF_RR : nva_pkg::OP_ON_RR;
      end
    endcase
  end

  // Event queue toward the engine.
  nva_fifo #(
    .W($bits(nva_pkg::evt_t))
  ) u_evt_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (push),
    .wr_data(cls),
    .full   (full),
    .rd_en  (evt_take),
    .rd_data(q_data),
    .empty  (q_empty)
  );

  assign evt_valid = ~q_empty;
  assign evt       = nva_pkg::evt_t'(q_data);

endmodule

>>> design/nva_engine.sv
// Allocation engine: holds device state and carries out one event per cycle while res_ready is high.
// Depends on nva_pkg.
module nva_engine #(
  parameter int DEVICES = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [3:0]    device_count,
  input  logic          evt_valid,
  output logic          evt_take,
  input  nva_pkg::evt_t evt,
  output logic          res_valid,
  input  logic          res_ready,
  output nva_pkg::res_t res
);

  localparam int DW = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int CW = $clog2(DEVICES + 1);

  logic [DEVICES-1:0]          busy;
  logic [nva_pkg::NOTE_W-1:0]  dev_note [DEVICES];
  logic [DW-1:0]               last_assigned;
  logic                        last_valid;

  logic [CW-1:0]      n;
  logic [DEVICES-1:0] active;
  logic [DEVICES-1:0] idle;
  logic [DEVICES-1:0] match;
  logic [DEVICES-1:0] on_hi;
  logic [DEVICES-1:0] off_lo;
  logic [DEVICES-1:0] touch;
  logic [DW-1:0]      start_on;
  logic [DW-1:0]      start_off;
  logic [DW-1:0]      first_idx;
  logic               go;
  logic               any;
  logic               is_on;
  logic [63:0]        touch_wide;
  logic [5:0]         first_wide;

  // Lowest set bit as a one-hot vector.
  function automatic logic [DEVICES-1:0] low_one(input logic [DEVICES-1:0] v);
    return v & (~v + DEVICES'(1));
  endfunction

  // Highest set bit as a one-hot vector.
  function automatic logic [DEVICES-1:0] high_one(input logic [DEVICES-1:0] v);
    logic [DEVICES-1:0] r;
    logic               hit;
    r   = '0;
    hit = 1'b0;
    for (int d = DEVICES - 1; d >= 0; d--) begin
      if (v[d] && !hit) begin
        r[d] = 1'b1;
        hit  = 1'b1;
      end
    end
    return r;
  endfunction

  // Index of the lowest set bit, zero when none.
  function automatic logic [DW-1:0] low_idx(input logic [DEVICES-1:0] v);
    logic [DW-1:0] idx;
    idx = '0;
    for (int d = DEVICES - 1; d >= 0; d--) begin
      if (v[d]) idx = DW'(d);
    end
    return idx;
  endfunction

  assign go        = evt_valid & res_ready;
  assign evt_take  = go;
  assign res_valid = go;

  // Devices taking part, with the count saturated to the chain length.
  always_comb begin
    if (32'(device_count) > 32'(DEVICES)) begin
      n = CW'(DEVICES);
    end else begin
      n = CW'(device_count);
    end
  end

  // Per-device compares.
  always_comb begin
    for (int d = 0; d < DEVICES; d++) begin
      active[d] = (32'(d) < 32'(n));
      idle[d]   = active[d] & ~busy[d];
      match[d]  = active[d] & busy[d] & (dev_note[d] == evt.note);
    end
  end

  // Round-robin start points and the wrapped search windows.
  always_comb begin
    if (last_valid && (32'(last_assigned) + 32'd1 < 32'(n))) begin
      start_on = DW'(32'(last_assigned) + 32'd1);
    end else begin
      start_on = '0;
    end
    if (last_assigned == '0 || 32'(last_assigned) >= 32'(n)) begin
      start_off = DW'(32'(n) - 32'd1);
    end else begin
      start_off = DW'(32'(last_assigned) - 32'd1);
    end
    for (int d = 0; d < DEVICES; d++) begin
      on_hi[d]  = idle[d] & (32'(d) >= 32'(start_on));
      off_lo[d] = match[d] & (32'(d) <= 32'(start_off));
    end
  end

  // Choose the devices this event touches.
  always_comb begin
    is_on = 1'b0;
    unique case (evt.op)
      nva_pkg::OP_ON_ALL: begin
        touch = idle;
        is_on = 1'b1;
      end
      nva_pkg::OP_ON_FIRST: begin
        touch = low_one(idle);
        is_on = 1'b1;
      end
      nva_pkg::OP_ON_RR: begin
        touch = (|on_hi) ? low_one(on_hi) : low_one(idle);
        is_on = 1'b1;
      end
      nva_pkg::OP_OFF_ALL: begin
        touch = match;
      end
      nva_pkg::OP_OFF_FIRST: begin
        touch = low_one(match);
      end
      nva_pkg::OP_OFF_RR: begin
        if (!last_valid) begin
          touch = '0;
        end else begin
          touch = (|off_lo) ? high_one(off_lo) : high_one(match);
        end
      end
      default: begin
        touch = '0;
      end
    endcase
  end

  assign any        = |touch;
  assign first_idx  = low_idx(touch);
  assign touch_wide = 64'(touch);
  assign first_wide = 6'(first_idx);

  // Result beat: only the first eight devices show in the mask.
  always_comb begin
    res.touched_mask = touch_wide[nva_pkg::MASK_W-1:0];
    res.found        = any;
    res.first_device = first_wide[nva_pkg::FIRST_W-1:0];
  end

  // Busy flags and round-robin position.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= '0;
      last_assigned <= '0;
      last_valid    <= 1'b0;
    end else if (go) begin
      if (is_on) begin
        busy <= busy | touch;
      end else begin
        busy <= busy & ~touch;
      end
      if (evt.op == nva_pkg::OP_ON_RR && any) begin
        last_assigned <= first_idx;
        last_valid    <= 1'b1;
      end
    end
  end

  // Note held by each device; only read while the device is busy.
  always_ff @(posedge clk) begin
    for (int d = 0; d < DEVICES; d++) begin
      if (go && is_on && touch[d]) begin
        dev_note[d] <= evt.note;
      end
    end
  end

endmodule

>>> design/note_voice_allocator.sv
// Top level of the note voice allocator: configuration registers and queues.
// Depends on nva_pkg, nva_fifo, nva_front and nva_engine.
//
// Note-on and note-off events enter through a two-entry queue, are allocated
// against the device chain by the engine's combinational compare and
// priority-encode step, and leave as result beats through a second two-entry
// queue. The block sustains one event per clock while results are popped as
// they appear; an event passes the event queue and the engine, which waits
// for room in the result queue; its result then shows on the ports. The user
// must write policy and device count over the APB port only while no event
// is in flight; the block itself does not enforce this. pready is always high.
module note_voice_allocator #(
  parameter int DEVICES = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Event side.
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [6:0]  note,
  // Result side.
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  touched_mask,
  output logic        found,
  output logic [2:0]  first_device
);

  logic [1:0]    policy;
  logic [3:0]    device_count;
  logic          cfg_wr;
  logic          evt_valid;
  logic          evt_take;
  nva_pkg::evt_t evt;
  logic          res_valid;
  logic          res_full;
  nva_pkg::res_t res;
  logic [$bits(nva_pkg::res_t)-1:0] out_data;
  nva_pkg::res_t out_beat;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= nva_pkg::POL_BCAST;
      device_count <= 4'd8;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        nva_pkg::REG_POLICY: policy       <= pwdata[1:0];
        nva_pkg::REG_COUNT:  device_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      nva_pkg::REG_POLICY: prdata = {30'd0, policy};
      nva_pkg::REG_COUNT:  prdata = {28'd0, device_count};
      default:             prdata = '0;
    endcase
  end

  nva_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .mode     (mode),
    .note     (note),
    .policy   (policy),
    .evt_valid(evt_valid),
    .evt_take (evt_take),
    .evt      (evt)
  );

  nva_engine #(
    .DEVICES(DEVICES)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .device_count(device_count),
    .evt_valid   (evt_valid),
    .evt_take    (evt_take),
    .evt         (evt),
    .res_valid   (res_valid),
    .res_ready   (~res_full),
    .res         (res)
  );

  // Result queue toward the consumer.
  nva_fifo #(
    .W($bits(nva_pkg::res_t))
  ) u_res_q (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (res_valid),
    .wr_data(res),
    .full   (res_full),
    .rd_en  (pop),
    .rd_data(out_data),
    .empty  (empty)
  );

  assign out_beat     = nva_pkg::res_t'(out_data);
  assign touched_mask = out_beat.touched_mask;
  assign found        = out_beat.found;
  assign first_device = out_beat.first_device;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for note_voice_allocator: directed rows, then random phases.
// Depends on nva_pkg and the note_voice_allocator RTL; holds its own allocation predictor.
module testbench;

  localparam int DEVICES = 8;

  // One row of the directed part: an event, or a register write between phases.
  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t     kind;
    logic          which;
    logic [3:0]    value;
    logic          ev_mode;
    logic [6:0]    ev_note;
    bit            pinned;
    nva_pkg::res_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        push = 1'b0;
  logic        full;
  logic        mode = nva_pkg::MODE_ON;
  logic [6:0]  note = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  touched_mask;
  logic        found;
  logic [2:0]  first_device;

  // Predictor state: configuration, device chain and round-robin position.
  logic [1:0]  cfg_policy = nva_pkg::POL_BCAST;
  logic [3:0]  cfg_count = 4'd8;
  logic        voice_busy [DEVICES];
  logic [6:0]  voice_note [DEVICES];
  int          rr_last = 0;
  bit          rr_valid = 1'b0;

  nva_pkg::res_t pending_results [$];
  stim_row_t     directed_rows [$];
  logic [6:0]    sounding [$];
  bit            pin_next = 1'b0;
  nva_pkg::res_t pin_value = '0;
  bit            calm = 1'b0;
  int            pop_hold = 0;
  int            errors = 0;
  int            events_taken = 0;
  int            beats_checked = 0;
  int            reg_writes = 0;

  note_voice_allocator uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full), .mode(mode), .note(note),
    .empty(empty), .pop(pop),
    .touched_mask(touched_mask), .found(found), .first_device(first_device)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The run is cut off here if the block stops making progress.
  initial begin
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

  task automatic report(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    if ($urandom_range(0, 4) != 0) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Marks device d in the result and sets its new busy flag and note.
  function automatic void touch(int d, logic claim, logic [6:0] ev_note,
                                inout nva_pkg::res_t r);
    voice_busy[d] = claim;
    voice_note[d] = claim ? ev_note : 7'd0;
    if (d < 8) r.touched_mask[d] = 1'b1;
    if (!r.found) r.first_device = d[2:0];
    r.found = 1'b1;
  endfunction

  // Applies one event to the predicted chain and returns the result beat it gives.
  function automatic nva_pkg::res_t allocate_event(logic ev_mode, logic [6:0] ev_note);
    nva_pkg::res_t r;
    int n, start, d;
    r = '0;
    n = (cfg_count > DEVICES) ? DEVICES : int'(cfg_count);
    if (n == 0) return r;
    if (ev_mode == nva_pkg::MODE_ON) begin
      if (cfg_policy == nva_pkg::POL_BCAST) begin
        for (int i = 0; i < n; i++)
          if (!voice_busy[i]) touch(i, 1'b1, ev_note, r);
      end else begin
        start = 0;
        if (cfg_policy != nva_pkg::POL_FIRST && rr_valid && rr_last + 1 < n)
          start = rr_last + 1;
        for (int i = 0; i < n; i++) begin
          d = (start + i) % n;
          if (!voice_busy[d]) begin
            touch(d, 1'b1, ev_note, r);
            if (cfg_policy != nva_pkg::POL_FIRST) begin
              rr_last = d;
              rr_valid = 1'b1;
            end
            break;
          end
        end
      end
    end else if (cfg_policy == nva_pkg::POL_BCAST || cfg_policy == nva_pkg::POL_FIRST) begin
      for (int i = 0; i < n; i++)
        if (voice_busy[i] && voice_note[i] == ev_note) begin
          touch(i, 1'b0, ev_note, r);
          if (cfg_policy == nva_pkg::POL_FIRST) break;
        end
    end else if (rr_valid) begin
      // Round-robin release searches backwards from the device before the last one assigned.
      start = (rr_last == 0 || rr_last >= n) ? n - 1 : rr_last - 1;
      for (int i = 0; i < n; i++) begin
        d = (start - i + n) % n;
        if (voice_busy[d] && voice_note[d] == ev_note) begin
          touch(d, 1'b0, ev_note, r);
          break;
        end
      end
    end
    return r;
  endfunction

  // Result side stalls at random, except in calm phases.
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      if (!calm && $urandom_range(0, 7) == 0) pop_hold = pick_gap();
    end
  end

  // Checks each result beat against the oldest expectation, then predicts accepted events.
  always @(posedge clk) begin
    nva_pkg::res_t want, r;
    if (!rst && pop && !empty) begin
      if (pending_results.size() == 0) begin
        report($sformatf("result beat with nothing expected: mask %02h", touched_mask));
      end else begin
        want = pending_results.pop_front();
        if (touched_mask !== want.touched_mask)
          report($sformatf("touched_mask %02h, expected %02h", touched_mask, want.touched_mask));
        if (found !== want.found)
          report($sformatf("found %0b, expected %0b", found, want.found));
        if (first_device !== want.first_device)
          report($sformatf("first_device %0d, expected %0d", first_device, want.first_device));
        beats_checked++;
      end
    end
    if (!rst && push && !full) begin
      r = allocate_event(mode, note);
      pending_results.push_back(pin_next ? pin_value : r);
      events_taken++;
    end
  end

  // Drives one event beat and waits until the block takes it.
  task automatic send_event(logic ev_mode, logic [6:0] ev_note, bit pinned,
                            nva_pkg::res_t want);
    @(negedge clk);
    pin_next = pinned;
    pin_value = want;
    push <= 1'b1;
    mode <= ev_mode;
    note <= ev_note;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Optional gap on the event side after an accepted beat.
  task automatic push_gap();
    int g;
    g = (calm || $urandom_range(0, 9) < 7) ? 0 : pick_gap();
    if (g > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
  endtask

  // Stops pushing and waits until every expected beat has come back.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes one register over APB, then reads it back.
  task automatic write_register(logic which, logic [3:0] value);
    logic [31:0] field_mask;
    field_mask = (which == nva_pkg::REG_POLICY) ? 32'h3 : 32'hF;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= {28'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (which == nva_pkg::REG_POLICY) cfg_policy = value[1:0];
    else cfg_count = value;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== ({28'd0, value} & field_mask))
      report($sformatf("register %0d reads %0h, expected %0h", which, prdata,
                       {28'd0, value} & field_mask));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    reg_writes++;
  endtask

  function automatic stim_row_t ev(logic m, logic [6:0] n, bit pinned = 1'b0,
                                   logic [7:0] mask = '0, logic fnd = 1'b0,
                                   logic [2:0] first = '0);
    stim_row_t row;
    row.kind = ROW_EVENT;
    row.which = nva_pkg::REG_POLICY;
    row.value = '0;
    row.ev_mode = m;
    row.ev_note = n;
    row.pinned = pinned;
    row.want = '{touched_mask: mask, found: fnd, first_device: first};
    return row;
  endfunction

  function automatic stim_row_t wr(logic which, logic [3:0] value);
    stim_row_t row;
    row = ev(nva_pkg::MODE_ON, 7'd0);
    row.kind = ROW_WRITE;
    row.which = which;
    row.value = value;
    return row;
  endfunction

  initial begin
    stim_row_t row;
    logic [1:0] pol;
    logic [3:0] cnt;
    logic [6:0] pick;
    int base, idx, roll;

    for (int i = 0; i < DEVICES; i++) begin
      voice_busy[i] = 1'b0;
      voice_note[i] = 7'd0;
    end

    // Broadcast after reset, note extremes, and a release that matches nothing.
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd127, 1'b1, 8'hFF, 1'b1, 3'd0));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd127, 1'b1, 8'hFF, 1'b1, 3'd0));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd0,   1'b1, 8'h00, 1'b0, 3'd0));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd0,   1'b1, 8'hFF, 1'b1, 3'd0));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd0,   1'b1, 8'hFF, 1'b1, 3'd0));
    // First available.
    directed_rows.push_back(wr(nva_pkg::REG_POLICY, {2'b00, nva_pkg::POL_FIRST}));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd10,  1'b1, 8'h01, 1'b1, 3'd0));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd20,  1'b1, 8'h02, 1'b1, 3'd1));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd10,  1'b1, 8'h01, 1'b1, 3'd0));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd30));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd99,  1'b1, 8'h00, 1'b0, 3'd0));
    // Round robin: a release before any assignment does nothing.
    directed_rows.push_back(wr(nva_pkg::REG_POLICY, {2'b00, nva_pkg::POL_RR}));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd20,  1'b1, 8'h00, 1'b0, 3'd0));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd40));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd50));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd20));
    // One device with the last assignment out of range, then a full device.
    directed_rows.push_back(wr(nva_pkg::REG_COUNT, 4'd1));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd60));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd30));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd61));
    // No device takes part.
    directed_rows.push_back(wr(nva_pkg::REG_COUNT, 4'd0));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd1,   1'b1, 8'h00, 1'b0, 3'd0));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd61,  1'b1, 8'h00, 1'b0, 3'd0));
    // Count above the chain size saturates; the spare policy code acts as round robin.
    directed_rows.push_back(wr(nva_pkg::REG_COUNT, 4'd15));
    directed_rows.push_back(wr(nva_pkg::REG_POLICY, 4'd3));
    directed_rows.push_back(ev(nva_pkg::MODE_ON,  7'd70));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd70));
    directed_rows.push_back(ev(nva_pkg::MODE_OFF, 7'd61));

    // Hold synchronous reset, then release it on a falling clock edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_register(row.which, row.value);
      end else begin
        send_event(row.ev_mode, row.ev_note, row.pinned, row.want);
        push_gap();
      end
    end

    // Random phases: mostly note-on/note-off pairs over a narrow note range, some noise.
    for (int phase = 0; phase < 16; phase++) begin
      settle();
      pol = 2'($urandom_range(0, 3));
      roll = $urandom_range(0, 19);
      if (roll == 0) cnt = 4'd0;
      else if (roll == 1) cnt = 4'($urandom_range(9, 15));
      else if (roll < 5) cnt = 4'd1;
      else cnt = 4'($urandom_range(2, 8));
      write_register(nva_pkg::REG_POLICY, {2'b00, pol});
      write_register(nva_pkg::REG_COUNT, cnt);
      calm = ($urandom_range(0, 3) == 0);
      base = $urandom_range(0, 120);
      for (int k = 0; k < 120; k++) begin
        if ($urandom_range(0, 99) < 55 || sounding.size() == 0) begin
          if ($urandom_range(0, 9) != 0) pick = 7'(base + int'($urandom_range(0, 7)));
          else pick = 7'($urandom_range(0, 127));
          if (sounding.size() < 16) sounding.push_back(pick);
          send_event(nva_pkg::MODE_ON, pick, 1'b0, '0);
        end else if ($urandom_range(0, 99) < 85) begin
          idx = $urandom_range(0, sounding.size() - 1);
          pick = sounding[idx];
          sounding.delete(idx);
          send_event(nva_pkg::MODE_OFF, pick, 1'b0, '0);
        end else begin
          send_event(nva_pkg::MODE_OFF, 7'($urandom_range(0, 127)), 1'b0, '0);
        end
        push_gap();
      end
    end

    // Drain, allow for the block's latency, then give the verdict.
    settle();
    calm = 1'b1;
    repeat (10) @(posedge clk);
    $display("Run covered %0d events and %0d checked result beats over %0d register writes.",
             events_taken, beats_checked, reg_writes);
    $display("All three policies were exercised with chain sizes from zero to above the limit.");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/nva_pkg.sv
design/nva_fifo.sv
design/nva_front.sv
design/nva_engine.sv
design/note_voice_allocator.sv
dv/testbench.sv
